/* rtl/tmcw_pkg.sv */
// ----------------------------------------------------------------------------
// tmcw_pkg
// Shared widths, character codes and cell type for the text console writer.
// ----------------------------------------------------------------------------
package tmcw_pkg;

  localparam int CHAR_W      = 8;
  localparam int ATTR_W      = 8;
  localparam int IDX_W       = 11;
  localparam int VCUR_W      = 11;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  localparam logic [ATTR_W-1:0] BLANK_ATTR = 8'h07;
  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h00;

  localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
  localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
  localparam logic [CHAR_W-1:0] CH_NL  = 8'h0A;

  localparam logic ACT_PUT  = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef struct packed {
    logic [ATTR_W-1:0] attr;
    logic [CHAR_W-1:0] chr;
  } cell_t;

endpackage

/* rtl/text_mode_console_writer_unit.sv */
// ----------------------------------------------------------------------------
// text_mode_console_writer_unit
// Text screen of ROWS x COLUMNS character/attribute cells with a write cursor,
// held in one synchronous memory and updated by read-modify-write.
// ----------------------------------------------------------------------------
// After reset the unit sweeps the screen memory to blank cells, one cell per
// cycle, before it takes its first input beat. Each input beat gives exactly
// one result beat. A NUL, a backspace at cell zero, or a newline that needs
// no scroll, goes straight to ST_DONE; a read, any other backspace or an
// ordinary character first passes ST_RDATA or ST_RMW, set by the registered
// memory read ahead of the result or the write. A scroll moves every cell
// below the top row up one row through the single memory port pair, then
// blanks the last row; a character that follows the scroll is then written
// through ST_RMW. The input is not taken while a beat is in work; a finished
// result waits in the output register without holding up the next input
// beat, though that beat's result waits in ST_DONE until the register frees.
// ----------------------------------------------------------------------------
module text_mode_console_writer_unit #(
  parameter int COLUMNS = tmcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tmcw_pkg::DEF_ROWS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_action,
  input  logic [tmcw_pkg::CHAR_W-1:0] in_char_code,
  input  logic                        in_end_of_write,
  input  logic [tmcw_pkg::IDX_W-1:0]  in_cell_index,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tmcw_pkg::CHAR_W-1:0] out_cell_char,
  output logic [tmcw_pkg::ATTR_W-1:0] out_cell_attribute,
  output logic [tmcw_pkg::VCUR_W-1:0] out_visible_cursor
);
  import tmcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(CELLS + 1);
  localparam int COLW  = $clog2(COLUMNS);

  localparam logic [CW-1:0]   CELLS_C    = CW'(CELLS);
  localparam logic [CW-1:0]   COLUMNS_C  = CW'(COLUMNS);
  localparam logic [CW-1:0]   LAST_ROW_C = CW'(CELLS - COLUMNS);
  localparam logic [CW-1:0]   LAST_C     = CW'(CELLS - 1);
  localparam logic [COLW-1:0] COL_LAST_C = COLW'(COLUMNS - 1);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_RDATA  = 3'd2;
  localparam logic [2:0] ST_RMW    = 3'd3;
  localparam logic [2:0] ST_SCROLL = 3'd4;
  localparam logic [2:0] ST_FILL   = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  localparam cell_t BLANK_CELL = '{attr: BLANK_ATTR, chr: BLANK_CHAR};

  // screen memory
  cell_t         mem [CELLS];
  cell_t         mem_q;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  cell_t         mem_wd;
  logic [AW-1:0] mem_ra;

  // control state
  logic [2:0]      state_r, state_nxt;
  logic [CW-1:0]   cur_r, cur_nxt;
  logic [COLW-1:0] col_r, col_nxt;
  logic [CW-1:0]   shown_r, shown_nxt;
  logic [CW-1:0]   sc_r, sc_nxt;
  logic            post_wr_r, post_wr_nxt;
  logic            out_valid_r, out_valid_nxt;

  // beat payload in work
  logic              act_r, act_nxt;
  logic              eow_r, eow_nxt;
  logic              oor_r, oor_nxt;
  logic [AW-1:0]     wr_addr_r, wr_addr_nxt;
  logic [CHAR_W-1:0] wchar_r, wchar_nxt;
  logic [CHAR_W-1:0] res_char_r, res_char_nxt;
  logic [ATTR_W-1:0] res_attr_r, res_attr_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic [ATTR_W-1:0] out_attr_r, out_attr_nxt;
  logic [VCUR_W-1:0] out_vcur_r, out_vcur_nxt;

  logic            in_acc;
  logic [CW:0]     line_start;
  logic [CW-1:0]   cur_dec;
  logic [COLW-1:0] col_inc;

  assign in_stall           = (state_r != ST_IDLE);
  assign in_acc             = in_valid && !in_stall;
  assign out_valid          = out_valid_r;
  assign out_cell_char      = out_char_r;
  assign out_cell_attribute = out_attr_r;
  assign out_visible_cursor = out_vcur_r;

  assign line_start = {1'b0, cur_r} - (CW + 1)'(col_r) + (CW + 1)'(COLUMNS);
  assign cur_dec    = cur_r - CW'(1);
  assign col_inc    = (col_r == COL_LAST_C) ? '0 : col_r + COLW'(1);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q <= mem[mem_ra];
  end

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    col_nxt       = col_r;
    shown_nxt     = shown_r;
    sc_nxt        = sc_r;
    post_wr_nxt   = post_wr_r;
    out_valid_nxt = out_valid_r && out_stall;
    act_nxt       = act_r;
    eow_nxt       = eow_r;
    oor_nxt       = oor_r;
    wr_addr_nxt   = wr_addr_r;
    wchar_nxt     = wchar_r;
    res_char_nxt  = res_char_r;
    res_attr_nxt  = res_attr_r;
    out_char_nxt  = out_char_r;
    out_attr_nxt  = out_attr_r;
    out_vcur_nxt  = out_vcur_r;
    mem_we        = 1'b0;
    mem_wa        = wr_addr_r;
    mem_wd        = BLANK_CELL;
    mem_ra        = sc_r[AW-1:0];

    unique case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = sc_r[AW-1:0];
        sc_nxt = sc_r + CW'(1);
        if (sc_r == LAST_C) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_acc) begin
          act_nxt      = in_action;
          eow_nxt      = in_end_of_write;
          res_char_nxt = '0;
          res_attr_nxt = '0;
          if (in_action == ACT_READ) begin
            mem_ra    = AW'(in_cell_index);
            oor_nxt   = (32'(in_cell_index) >= CELLS);
            state_nxt = ST_RDATA;
          end else begin
            unique case (in_char_code)
              CH_NUL: begin
                state_nxt = ST_DONE;
              end
              CH_NL: begin
                if (line_start >= (CW + 1)'(CELLS)) begin
                  post_wr_nxt = 1'b0;
                  sc_nxt      = COLUMNS_C;
                  state_nxt   = ST_SCROLL;
                end else begin
                  cur_nxt   = line_start[CW-1:0];
                  col_nxt   = '0;
                  state_nxt = ST_DONE;
                end
              end
              CH_BS: begin
                if (cur_r != '0) begin
                  cur_nxt     = cur_dec;
                  col_nxt     = (col_r == '0) ? COL_LAST_C : col_r - COLW'(1);
                  wr_addr_nxt = cur_dec[AW-1:0];
                  mem_ra      = cur_dec[AW-1:0];
                  wchar_nxt   = BLANK_CHAR;
                  state_nxt   = ST_RMW;
                end else begin
                  state_nxt = ST_DONE;
                end
              end
              default: begin
                wchar_nxt = in_char_code;
                if (cur_r == CELLS_C) begin
                  post_wr_nxt = 1'b1;
                  sc_nxt      = COLUMNS_C;
                  state_nxt   = ST_SCROLL;
                end else begin
                  wr_addr_nxt = cur_r[AW-1:0];
                  mem_ra      = cur_r[AW-1:0];
                  cur_nxt     = cur_r + CW'(1);
                  col_nxt     = col_inc;
                  state_nxt   = ST_RMW;
                end
              end
            endcase
          end
        end
      end

      ST_RDATA: begin
        if (!oor_r) begin
          res_char_nxt = mem_q.chr;
          res_attr_nxt = mem_q.attr;
        end
        state_nxt = ST_DONE;
      end

      ST_RMW: begin
        // keep the stored attribute, replace the character
        mem_we    = 1'b1;
        mem_wa    = wr_addr_r;
        mem_wd    = '{attr: mem_q.attr, chr: wchar_r};
        state_nxt = ST_DONE;
      end

      ST_SCROLL: begin
        // read one row ahead, write last cycle's read one row up
        if (sc_r != COLUMNS_C) begin
          mem_we = 1'b1;
          mem_wa = AW'(sc_r - COLUMNS_C - CW'(1));
          mem_wd = mem_q;
        end
        if (sc_r == CELLS_C) begin
          sc_nxt    = LAST_ROW_C;
          state_nxt = ST_FILL;
        end else begin
          sc_nxt = sc_r + CW'(1);
        end
      end

      ST_FILL: begin
        mem_we = 1'b1;
        mem_wa = sc_r[AW-1:0];
        sc_nxt = sc_r + CW'(1);
        if (sc_r == LAST_C) begin
          if (post_wr_r) begin
            wr_addr_nxt = LAST_ROW_C[AW-1:0];
            mem_ra      = LAST_ROW_C[AW-1:0];
            cur_nxt     = LAST_ROW_C + CW'(1);
            col_nxt     = COLW'(1);
            state_nxt   = ST_RMW;
          end else begin
            cur_nxt   = LAST_ROW_C;
            col_nxt   = '0;
            state_nxt = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          if (act_r == ACT_PUT && eow_r) begin
            shown_nxt = cur_r;
          end
          out_char_nxt  = res_char_r;
          out_attr_nxt  = res_attr_r;
          out_vcur_nxt  = (act_r == ACT_PUT && eow_r) ? VCUR_W'(cur_r) : VCUR_W'(shown_r);
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cur_r       <= '0;
      col_r       <= '0;
      shown_r     <= '0;
      sc_r        <= '0;
      post_wr_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      col_r       <= col_nxt;
      shown_r     <= shown_nxt;
      sc_r        <= sc_nxt;
      post_wr_r   <= post_wr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    eow_r      <= eow_nxt;
    oor_r      <= oor_nxt;
    wr_addr_r  <= wr_addr_nxt;
    wchar_r    <= wchar_nxt;
    res_char_r <= res_char_nxt;
    res_attr_r <= res_attr_nxt;
    out_char_r <= out_char_nxt;
    out_attr_r <= out_attr_nxt;
    out_vcur_r <= out_vcur_nxt;
  end

endmodule
